// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/cmap_pkg.sv =====
// Package for the format-4 glyph lookup: word types, constants and codes.
// Depends on nothing.
`default_nettype none
package cmap_pkg;
    localparam int MaxSegments = 64;
    localparam int RegionDepth = 1024;
    localparam int SegIdxW = $clog2(MaxSegments);
    localparam int RegAddrW = $clog2(RegionDepth);

    localparam logic [1:0] CmdWriteSeg = 2'd0;
    localparam logic [1:0] CmdWriteWord = 2'd1;
    localparam logic [1:0] CmdLookup = 2'd2;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StMalformed = 2'd1;
    localparam logic [1:0] StRange = 2'd2;
    localparam logic [1:0] StDouble = 2'd3;

    localparam logic RegSegCount = 1'b0;
    localparam logic RegRegionWords = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  slot;
        logic [15:0] seg_start;
        logic [15:0] seg_end;
        logic [15:0] seg_delta;
        logic [15:0] word_value;
        logic [15:0] char_code;
    } t_in_word;

    typedef struct packed {
        logic [15:0] glyph;
        logic        mapped;
        logic [1:0]  status;
    } t_out_word;

    typedef struct packed {
        logic [15:0] seg_start;
        logic [15:0] seg_end;
        logic [15:0] seg_delta;
    } t_segment;
endpackage
`default_nettype wire

// ===== rtl/cmap_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module cmap_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/cmap_cell.sv =====
// One segment cell of the shift chain; holds a segment and passes it on.
// Depends on cmap_pkg.
`default_nettype none
module cmap_cell (
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire logic               i_shift,
    input  wire cmap_pkg::t_segment i_load_seg,
    input  wire cmap_pkg::t_segment i_prev_seg,
    output cmap_pkg::t_segment      o_seg
);
    import cmap_pkg::*;

    t_segment r_seg;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_seg <= i_load_seg;
        end else if (i_shift) begin
            r_seg <= i_prev_seg;
        end
    end

    assign o_seg = r_seg;
endmodule
`default_nettype wire

// ===== rtl/cmap_format4_glyph_lookup.sv =====
// Format-4 glyph lookup: a chain of segment cells rotates one segment per step
// past a scan unit; a lookup steps through all 64 chain positions and rotates
// the chain back home before the result is valid (with no segments, it does
// not rotate). A matching segment adds a region read (S_ROFF) and, for a
// nonzero offset, a word read (S_WORD); an error at position 0 goes to S_OUT.
// A word is taken when idle and not stalled. Reset clears control state only.
`default_nettype none
`include "assert_macros.svh"
module cmap_format4_glyph_lookup (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire cmap_pkg::t_in_word  i_word,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output cmap_pkg::t_out_word      o_word,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import cmap_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ROFF, S_WORD, S_NEXT, S_OUT} t_state;

    t_state r_state;
    logic [6:0] r_seg_count;
    logic [10:0] r_region_words;
    logic [SegIdxW:0] r_pos;
    logic [SegIdxW:0] r_left;
    logic [15:0] r_code;
    logic [15:0] r_found;
    logic r_have;
    t_out_word r_out;
    logic r_out_valid;
    logic [15:0] r_lo;
    logic [15:0] r_delta;
    logic [SegIdxW:0] r_s;

    t_segment w_seg [MaxSegments];
    logic w_accept, w_shift;
    logic [15:0] w_rdata;
    logic [RegAddrW-1:0] w_raddr;
    logic [17:0] w_addr;
    logic [6:0] w_count;

    assign pready = 1'b1;
    assign o_stall = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_accept = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_word = r_out;
    assign w_count = (r_seg_count > 7'(MaxSegments)) ? 7'(MaxSegments) : r_seg_count;

    always_comb begin
        unique case (paddr[2])
            RegSegCount:    prdata = {25'd0, r_seg_count};
            RegRegionWords: prdata = {21'd0, r_region_words};
            default:        prdata = 32'd0;
        endcase
    end

    // The chain rotates by one position in every scan step.
    assign w_shift = (r_state == S_SCAN);

    // Segment writes load the cell of their slot directly.
    genvar g;
    for (g = 0; g < MaxSegments; g++) begin : g_cell
        cmap_cell u_cell (
            .i_clk     (i_clk),
            .i_load    (w_accept && i_word.command == CmdWriteSeg
                        && i_word.slot == 10'(g)),
            .i_shift   (w_shift),
            .i_load_seg({i_word.seg_start, i_word.seg_end, i_word.seg_delta}),
            .i_prev_seg(w_seg[(g + 1) % MaxSegments]),
            .o_seg     (w_seg[g])
        );
    end

    assign w_addr = 18'(r_s) + 18'(w_rdata[15:1]) + 18'(r_code - r_lo);

    always_comb begin
        w_raddr = RegAddrW'(r_s);
        if (r_state == S_ROFF) begin
            w_raddr = w_addr[RegAddrW-1:0];
        end
    end

    cmap_ram #(.Width(16), .Depth(RegionDepth)) u_region (
        .i_clk  (i_clk),
        .i_we   (w_accept && i_word.command == CmdWriteWord),
        .i_waddr(i_word.slot[RegAddrW-1:0]),
        .i_wdata(i_word.word_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    task automatic finish(input logic [15:0] res_glyph, input logic [1:0] res_status);
        r_out <= '{glyph: res_glyph, mapped: (res_glyph != 16'd0), status: res_status};
        r_out_valid <= 1'b1;
        r_state <= S_IDLE;
    endtask

    logic [15:0] w_glyph;
    assign w_glyph = w_rdata + r_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_seg_count <= '0;
            r_region_words <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[2])
                    RegSegCount:    r_seg_count <= pwdata[6:0];
                    RegRegionWords: r_region_words <= pwdata[10:0];
                    default:        ;
                endcase
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_word.command == CmdLookup) begin
                        r_code <= i_word.char_code;
                        r_found <= '0;
                        r_have <= 1'b0;
                        r_s <= '0;
                        r_pos <= '0;
                        r_left <= (SegIdxW+1)'(w_count);
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_left == '0) begin
                        // Rotate back home before finishing.
                        if (r_pos == '0) begin
                            finish(r_found, StOk);
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else if (w_seg[0].seg_start > w_seg[0].seg_end) begin
                        r_left <= '0;
                        r_out <= '{glyph: 16'd0, mapped: 1'b0, status: StMalformed};
                        r_have <= 1'b1;
                        r_state <= (r_pos == '0) ? S_OUT : S_SCAN;
                    end else if (r_code < w_seg[0].seg_start
                                 || r_code > w_seg[0].seg_end) begin
                        r_state <= S_SCAN;
                    end else if (11'(r_s) >= 11'(RegionDepth)
                                 || 11'(r_s) >= r_region_words) begin
                        r_left <= '0;
                        r_out <= '{glyph: 16'd0, mapped: 1'b0, status: StRange};
                        r_have <= 1'b1;
                        r_state <= (r_pos == '0) ? S_OUT : S_SCAN;
                    end else begin
                        r_lo <= w_seg[0].seg_start;
                        r_delta <= w_seg[0].seg_delta;
                        r_state <= S_ROFF;
                    end
                end
                S_ROFF: begin
                    if (w_rdata == 16'd0) begin
                        if ((r_code + r_delta) != 16'd0) begin
                            if (r_found != 16'd0) begin
                                r_left <= '0;
                                r_out <= '{glyph: 16'd0, mapped: 1'b0,
                                           status: StDouble};
                                r_have <= 1'b1;
                                r_state <= (r_pos == '0) ? S_OUT : S_SCAN;
                            end else begin
                                r_found <= r_code + r_delta;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else if (w_addr >= 18'(r_region_words)
                                 || w_addr >= 18'(RegionDepth)) begin
                        r_left <= '0;
                        r_out <= '{glyph: 16'd0, mapped: 1'b0, status: StRange};
                        r_have <= 1'b1;
                        r_state <= (r_pos == '0) ? S_OUT : S_SCAN;
                    end else begin
                        r_state <= S_WORD;
                    end
                end
                S_WORD: begin
                    if (w_rdata != 16'd0 && w_glyph != 16'd0) begin
                        if (r_found != 16'd0) begin
                            r_left <= '0;
                            r_out <= '{glyph: 16'd0, mapped: 1'b0, status: StDouble};
                            r_have <= 1'b1;
                            r_state <= (r_pos == '0) ? S_OUT : S_SCAN;
                        end else begin
                            r_found <= w_glyph;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // One rotation of the chain per visit.
                    r_pos <= (r_pos == (SegIdxW+1)'(MaxSegments - 1)) ? '0 : r_pos + 1'b1;
                    if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                        r_s <= r_s + 1'b1;
                    end
                    if (r_left == '0 && r_pos == (SegIdxW+1)'(MaxSegments - 1)) begin
                        if (r_have) begin
                            r_out_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            finish(r_found, StOk);
                        end
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `ASSERT_IMPL(a_out_status_clean, i_clk, i_rst_n,
                 o_valid && o_word.status != StOk, o_word.glyph == 16'd0)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
endmodule
`default_nettype wire
